@@ src/tip_pkg.sv @@
// Shared types, constants and helper functions of the text integer parser.
`timescale 1ns / 1ps
`default_nettype none

package tip_pkg;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int BASE_W   = 6;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 16;
    localparam int PROD_W   = VALUE_W + BASE_W;

    typedef logic [CHAR_W-1:0]   char_t;
    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [BASE_W-1:0]   base_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [OFFSET_W-1:0] offset_t;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_BAD_BASE = 2'd1;
    localparam status_t STATUS_RANGE    = 2'd2;

    localparam logic CFG_NUMBER_BASE = 1'b0;
    localparam logic CFG_SIGNED_MODE = 1'b1;

    localparam base_t NUMBER_BASE_RESET = 6'd10;
    localparam logic  SIGNED_MODE_RESET = 1'b1;

    localparam base_t BASE_AUTO    = 6'd0;
    localparam base_t BASE_OCTAL   = 6'd8;
    localparam base_t BASE_DECIMAL = 6'd10;
    localparam base_t BASE_HEX     = 6'd16;
    localparam base_t BASE_MAX     = 6'd36;
    localparam base_t DIGIT_NONE   = 6'd36;

    localparam value_t SIGNED_NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam value_t SIGNED_POS_LIMIT = 64'h7fff_ffff_ffff_ffff;
    localparam value_t UNSIGNED_LIMIT   = 64'hffff_ffff_ffff_ffff;

    typedef struct packed {
        base_t number_base;
        logic  signed_mode;
    } tip_cfg_t;

    typedef struct packed {
        logic  advance;
        logic  digit_en;
        base_t digit;
        base_t base;
        logic  cap_zero;
        logic  end_zero;
        logic  finish;
        logic  bad;
        logic  resolve;
        logic  minus;
    } tip_cmd_t;

    function automatic base_t digit_value(input char_t c);
        base_t d;
        d = DIGIT_NONE;
        if (c inside {["0":"9"]})
        begin
            d = BASE_W'(c - "0");
        end
        else if (c inside {["a":"z"]})
        begin
            d = BASE_W'(c - "a" + 8'd10);
        end
        else if (c inside {["A":"Z"]})
        begin
            d = BASE_W'(c - "A" + 8'd10);
        end
        return d;
    endfunction

    function automatic logic base_invalid(input base_t b);
        return (b == 6'd1) || (b > BASE_MAX);
    endfunction

endpackage

`default_nettype wire

@@ src/tip_text_if.sv @@
// Input channel: one character word of the string per handshake.
`timescale 1ns / 1ps
`default_nettype none

interface tip_text_if
    import tip_pkg::*;
;
    logic  valid;
    logic  ready;
    char_t text_char;
    logic  last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

@@ src/tip_result_if.sv @@
// Output channel: one conversion result word per string.
`timescale 1ns / 1ps
`default_nettype none

interface tip_result_if
    import tip_pkg::*;
;
    logic    valid;
    logic    ready;
    value_t  result_bits;
    logic    is_negative;
    status_t status;
    offset_t end_offset;

    modport source (output valid, output result_bits, output is_negative, output status,
                    output end_offset, input ready);
    modport sink (input valid, input result_bits, input is_negative, input status,
                  input end_offset, output ready);
endinterface

`default_nettype wire

@@ src/tip_cfg.sv @@
// APB register file holding the digit base and signed mode.
`timescale 1ns / 1ps
`default_nettype none

module tip_cfg
    import tip_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output tip_cfg_t         cfg
);

    base_t number_base_reg;
    logic  signed_mode_reg;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= NUMBER_BASE_RESET;
            signed_mode_reg <= SIGNED_MODE_RESET;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                CFG_NUMBER_BASE: number_base_reg <= pwdata[BASE_W-1:0];
                CFG_SIGNED_MODE: signed_mode_reg <= pwdata[0];
                default:         number_base_reg <= number_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            CFG_NUMBER_BASE: prdata = 32'(number_base_reg);
            CFG_SIGNED_MODE: prdata = 32'(signed_mode_reg);
            default:         prdata = 32'd0;
        endcase
    end

    assign cfg.number_base = number_base_reg;
    assign cfg.signed_mode = signed_mode_reg;

endmodule

`default_nettype wire

@@ src/tip_ctrl.sv @@
// Parse controller: phase tracking, digit classification and handshake control.
`timescale 1ns / 1ps
`default_nettype none

module tip_ctrl
    import tip_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire char_t    text_char,
    input  wire logic     last_char,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire tip_cfg_t cfg,
    output tip_cmd_t      cmd
);

    localparam logic [2:0] PH_SPACE   = 3'd0;
    localparam logic [2:0] PH_FIRST   = 3'd1;
    localparam logic [2:0] PH_ZERO    = 3'd2;
    localparam logic [2:0] PH_ZEROX   = 3'd3;
    localparam logic [2:0] PH_DIGITS  = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;
    localparam logic [2:0] PH_BADBASE = 3'd6;

    logic [2:0] phase_reg, phase_next;
    base_t      base_reg, base_next;
    logic       minus_reg, minus_next;
    logic       out_valid_reg, out_valid_next;

    logic       fire;
    base_t      dval;
    logic       take_dig;
    base_t      dig_base;
    logic       start_zero;

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign fire      = in_valid && in_ready;
    assign dval      = digit_value(text_char);

    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        minus_next = minus_reg;
        cmd        = '0;
        cmd.minus  = minus_reg;
        take_dig   = 1'b0;
        dig_base   = base_reg;
        start_zero = 1'b0;

        if (fire && last_char)
        begin
            cmd.finish = 1'b1;
            cmd.bad    = (((phase_reg == PH_SPACE) || (phase_reg == PH_FIRST))
                          && base_invalid(cfg.number_base))
                         || (phase_reg == PH_BADBASE);
            cmd.resolve = (phase_reg == PH_ZERO) || (phase_reg == PH_ZEROX);
            phase_next = PH_SPACE;
            base_next  = BASE_AUTO;
            minus_next = 1'b0;
        end
        else if (fire)
        begin
            cmd.advance = 1'b1;
            case (phase_reg)
                PH_SPACE:
                begin
                    if (text_char inside {8'h20, [8'h09:8'h0d]})
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (text_char inside {"-", "+"})
                    begin
                        minus_next = (text_char == "-");
                        phase_next = PH_FIRST;
                    end
                    else
                    begin
                        start_zero = 1'b1;
                    end
                end
                PH_FIRST:
                begin
                    start_zero = 1'b1;
                end
                PH_ZERO:
                begin
                    if (text_char inside {"x", "X"})
                    begin
                        phase_next = PH_ZEROX;
                    end
                    else
                    begin
                        dig_base     = (base_reg == BASE_AUTO) ? BASE_OCTAL : base_reg;
                        base_next    = dig_base;
                        cmd.end_zero = 1'b1;
                        phase_next   = PH_DIGITS;
                        take_dig     = 1'b1;
                    end
                end
                PH_ZEROX:
                begin
                    if (dval < BASE_HEX)
                    begin
                        dig_base   = BASE_HEX;
                        base_next  = BASE_HEX;
                        phase_next = PH_DIGITS;
                        take_dig   = 1'b1;
                    end
                    else
                    begin
                        base_next    = (base_reg == BASE_AUTO) ? BASE_OCTAL : base_reg;
                        cmd.end_zero = 1'b1;
                        phase_next   = PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    take_dig = 1'b1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (start_zero)
            begin
                base_next = cfg.number_base;
                if (base_invalid(cfg.number_base))
                begin
                    phase_next = PH_BADBASE;
                end
                else if (((cfg.number_base == BASE_AUTO) || (cfg.number_base == BASE_HEX))
                         && (text_char == "0"))
                begin
                    phase_next   = PH_ZERO;
                    cmd.cap_zero = 1'b1;
                end
                else
                begin
                    dig_base   = (cfg.number_base == BASE_AUTO) ? BASE_DECIMAL
                                                                 : cfg.number_base;
                    base_next  = dig_base;
                    phase_next = PH_DIGITS;
                    take_dig   = 1'b1;
                end
            end

            if (take_dig)
            begin
                if (dval < dig_base)
                begin
                    cmd.digit_en = 1'b1;
                    cmd.digit    = dval;
                    cmd.base     = (dig_base < 6'd2) ? BASE_DECIMAL : dig_base;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SPACE;
            base_reg      <= BASE_AUTO;
            minus_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            base_reg      <= base_next;
            minus_reg     <= minus_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ src/tip_dp.sv @@
// Parse datapath: digit multiply-accumulate, limit check, positions and result word.
`timescale 1ns / 1ps
`default_nettype none

module tip_dp
    import tip_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_LEN = 65535
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tip_cmd_t cmd,
    input  wire tip_cfg_t cfg,
    output value_t        result_bits,
    output logic          is_negative,
    output status_t       status,
    output offset_t       end_offset
);

    localparam int POS_W = $clog2(MAX_TEXT_LEN + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT_LEN);

    value_t           acc_reg;
    logic             ovf_reg;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] end_reg;
    logic [POS_W-1:0] zpos_reg;

    value_t  bits_reg;
    logic    neg_reg;
    status_t status_reg;
    offset_t offset_reg;

    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  zpos_inc;
    logic [POS_W-1:0]  end_sel;
    logic [63:0]       end_wide;
    logic [PROD_W-1:0] prod;
    value_t            limit;
    logic              over;
    value_t            val;
    value_t            bits;

    assign pos_inc  = (pos_reg == MAX_POS) ? pos_reg : pos_reg + 1'b1;
    assign zpos_inc = (zpos_reg == MAX_POS) ? zpos_reg : zpos_reg + 1'b1;

    always_comb
    begin
        if (cfg.signed_mode)
        begin
            limit = cmd.minus ? SIGNED_NEG_LIMIT : SIGNED_POS_LIMIT;
        end
        else
        begin
            limit = UNSIGNED_LIMIT;
        end
    end

    assign prod = PROD_W'(acc_reg) * PROD_W'(cmd.base) + PROD_W'(cmd.digit);
    assign over = prod > PROD_W'(limit);

    assign val = ovf_reg ? limit : acc_reg;

    always_comb
    begin
        if (cfg.signed_mode)
        begin
            bits = cmd.minus ? (64'd0 - val) : val;
        end
        else
        begin
            bits = (cmd.minus && !ovf_reg) ? (64'd0 - val) : val;
        end
    end

    assign end_sel  = cmd.resolve ? zpos_inc : end_reg;
    assign end_wide = 64'(end_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
            pos_reg  <= '0;
            end_reg  <= '0;
            zpos_reg <= '0;
        end
        else if (cmd.finish)
        begin
            acc_reg  <= '0;
            ovf_reg  <= 1'b0;
            pos_reg  <= '0;
            end_reg  <= '0;
            zpos_reg <= '0;
        end
        else
        begin
            if (cmd.advance)
            begin
                pos_reg <= pos_inc;
            end
            if (cmd.cap_zero)
            begin
                zpos_reg <= pos_reg;
            end
            if (cmd.end_zero && !cmd.digit_en)
            begin
                end_reg <= zpos_inc;
            end
            if (cmd.digit_en)
            begin
                if (over)
                begin
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= prod[VALUE_W-1:0];
                end
                end_reg <= pos_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            neg_reg <= cmd.minus;
            if (cmd.bad)
            begin
                bits_reg   <= '0;
                status_reg <= STATUS_BAD_BASE;
                offset_reg <= '0;
            end
            else
            begin
                bits_reg   <= bits;
                status_reg <= ovf_reg ? STATUS_RANGE : STATUS_OK;
                offset_reg <= end_wide[OFFSET_W-1:0];
            end
        end
    end

    assign result_bits = bits_reg;
    assign is_negative = neg_reg;
    assign status      = status_reg;
    assign end_offset  = offset_reg;

endmodule

`default_nettype wire

@@ src/text_integer_parser_unit.sv @@
// Top level of the streaming text-to-integer converter.
//
// Usage: send the characters of a string as words on text_in, one byte per
// word, the final word carrying last_char = 1 (its byte is not parsed). One
// result word per string appears on result_out with the converted 64-bit
// pattern, the sign seen, a status code and the offset after the last digit.
// number_base and signed_mode sit at APB byte addresses 0 and 4; write them
// only while no string is in flight.
// Throughput: one character word per cycle unless a waiting result holds off text_in. Each word is parsed in the cycle
// it is accepted; the digit step is a single 64-by-6-bit multiply-accumulate
// with a limit compare, which sets the per-word cost.
// Latency: the result word is valid the cycle after the final word is taken.
// Stall: a waiting result is held in the output register; text_in stays
// ready as long as result_out is taken in the same cycle, else it holds off.
// Reset: clears the parse state and the output valid; the base returns to
// 10 and signed mode to 1.
`timescale 1ns / 1ps
`default_nettype none

module text_integer_parser_unit
    import tip_pkg::*;
#(
    parameter longint unsigned MAX_TEXT_LEN = 65535
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    tip_text_if.sink         text_in,
    tip_result_if.source     result_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    tip_cfg_t cfg;
    tip_cmd_t cmd;

    tip_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (text_in.valid),
        .in_ready  (text_in.ready),
        .text_char (text_in.text_char),
        .last_char (text_in.last_char),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cfg       (cfg),
        .cmd       (cmd)
    );

    tip_dp #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .result_bits (result_out.result_bits),
        .is_negative (result_out.is_negative),
        .status      (result_out.status),
        .end_offset  (result_out.end_offset)
    );

endmodule

`default_nettype wire
